// ===== rtl/csba_pkg.sv =====
// ----------------------------------------------------------------------------
// csba_pkg
// Shared types and constants of the contiguous seat block allocator: grid
// size, action and slot codes, item structs and the row cell interface.
// ----------------------------------------------------------------------------
`default_nettype none

package csba_pkg;

  // Grid size
  localparam int ROWS  = 8;
  localparam int COLS  = 14;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;

  // Width that holds any slot index plus one row of headroom
  localparam int IDX_W = $clog2(ROWS * COLS + COLS + 128);

  // Action codes
  localparam logic [1:0] ACT_TOGGLE = 2'd0;
  localparam logic [1:0] ACT_CLAIM  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // Slot codes
  localparam logic [1:0] SLOT_FREE     = 2'd0;
  localparam logic [1:0] SLOT_RESERVED = 2'd1;
  localparam logic [1:0] SLOT_TAKEN    = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] slot_index;
    logic [3:0] run_length;
  } in_t;

  typedef struct packed {
    logic       changed;
    logic [2:0] block_row;
    logic [3:0] block_top_col;
    logic [1:0] slot_status;
  } out_t;

  // Search token walking down the row cells
  typedef struct packed {
    logic       valid;
    logic [3:0] len;
  } tok_t;

  // Broadcast single-cycle operation
  typedef struct packed {
    logic       toggle_go;
    logic       clear_go;
    logic [6:0] idx;
  } op_t;

  // Per-row response: nonfree always, all else zero unless this row acted
  typedef struct packed {
    logic             claim_hit;
    logic [ROW_W-1:0] claim_row;
    logic [COL_W-1:0] claim_top;
    logic             tg_changed;
    logic [1:0]       tg_status;
    logic             nonfree;
  } resp_t;

endpackage

`default_nettype wire

// ===== rtl/csba_cell.sv =====
// ----------------------------------------------------------------------------
// csba_cell
// One grid row: holds its slot codes, finds the highest-topped free run for
// a passing search token, and applies toggles and clears aimed at the row.
// ----------------------------------------------------------------------------
`default_nettype none

module csba_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [csba_pkg::ROW_W-1:0]  row_id,
  input  wire csba_pkg::op_t               op,
  input  wire csba_pkg::tok_t              tok_in,
  output csba_pkg::tok_t                   tok_out,
  output csba_pkg::resp_t                  resp
);

  logic [1:0]                 slot_r   [csba_pkg::COLS];
  logic [1:0]                 slot_nxt [csba_pkg::COLS];
  csba_pkg::tok_t             tok_r;
  logic [csba_pkg::COLS-1:0]  free_v;
  logic [csba_pkg::COLS-1:0]  win;
  logic                       win_any;
  logic [csba_pkg::COL_W-1:0] top;
  logic [csba_pkg::IDX_W-1:0] idx_ext;
  logic [csba_pkg::IDX_W-1:0] base;
  logic [csba_pkg::IDX_W-1:0] col_full;
  logic [csba_pkg::COL_W-1:0] tg_col;
  logic                       tg_here;
  logic                       claim_go;
  logic [1:0]                 tg_old;
  logic [1:0]                 tg_new;
  logic                       nonfree;

  // Free map of the row
  always_comb begin
    for (int c = 0; c < csba_pkg::COLS; c++) begin
      free_v[c] = (slot_r[c] == csba_pkg::SLOT_FREE);
    end
  end

  // Window check per top column: len slots ending at c, all free
  always_comb begin
    for (int c = 0; c < csba_pkg::COLS; c++) begin
      win[c] = (c + 1 >= int'(tok_r.len)) && (tok_r.len != 4'd0);
      for (int j = 0; j < csba_pkg::COLS; j++) begin
        if (j <= c && j + int'(tok_r.len) > c && !free_v[j]) begin
          win[c] = 1'b0;
        end
      end
    end
  end

  // Pick the highest qualifying top column
  always_comb begin
    win_any = 1'b0;
    top     = '0;
    for (int c = 0; c < csba_pkg::COLS; c++) begin
      if (win[c]) begin
        win_any = 1'b1;
        top     = csba_pkg::COL_W'(c);
      end
    end
  end

  assign claim_go = tok_r.valid && win_any;

  // Toggle addressing
  assign idx_ext  = csba_pkg::IDX_W'(op.idx);
  assign base     = csba_pkg::IDX_W'(row_id) * csba_pkg::IDX_W'(csba_pkg::COLS);
  assign col_full = idx_ext - base;
  assign tg_col   = col_full[csba_pkg::COL_W-1:0];
  assign tg_here  = op.toggle_go && (idx_ext >= base) &&
                    (idx_ext < base + csba_pkg::IDX_W'(csba_pkg::COLS));
  assign tg_old   = slot_r[tg_col];

  always_comb begin
    case (tg_old)
      csba_pkg::SLOT_FREE:     tg_new = csba_pkg::SLOT_RESERVED;
      csba_pkg::SLOT_RESERVED: tg_new = csba_pkg::SLOT_FREE;
      default:                 tg_new = tg_old;
    endcase
  end

  always_comb begin
    nonfree = 1'b0;
    for (int c = 0; c < csba_pkg::COLS; c++) begin
      if (!free_v[c]) begin
        nonfree = 1'b1;
      end
    end
  end

  // Next slot codes
  always_comb begin
    for (int c = 0; c < csba_pkg::COLS; c++) begin
      slot_nxt[c] = slot_r[c];
      if (op.clear_go) begin
        slot_nxt[c] = csba_pkg::SLOT_FREE;
      end else if (tg_here && tg_col == csba_pkg::COL_W'(c)) begin
        slot_nxt[c] = tg_new;
      end else if (claim_go && c <= int'(top) &&
                   c + int'(tok_r.len) > int'(top)) begin
        slot_nxt[c] = csba_pkg::SLOT_TAKEN;
      end
    end
  end

  // Hold slots and the token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < csba_pkg::COLS; c++) begin
        slot_r[c] <= csba_pkg::SLOT_FREE;
      end
      tok_r <= '0;
    end else begin
      for (int c = 0; c < csba_pkg::COLS; c++) begin
        slot_r[c] <= slot_nxt[c];
      end
      tok_r <= tok_in;
    end
  end

  // Pass the token on when this row has no fit
  assign tok_out.valid = tok_r.valid && !win_any;
  assign tok_out.len   = tok_r.len;

  // Report
  assign resp.claim_hit  = claim_go;
  assign resp.claim_row  = claim_go ? row_id : '0;
  assign resp.claim_top  = claim_go ? top : '0;
  assign resp.tg_changed = tg_here && (tg_old != tg_new);
  assign resp.tg_status  = tg_here ? tg_new : csba_pkg::SLOT_FREE;
  assign resp.nonfree    = nonfree;

endmodule

`default_nettype wire

// ===== rtl/contiguous_seat_block_allocator.sv =====
// ----------------------------------------------------------------------------
// contiguous_seat_block_allocator
// Slot grid with toggle reserve, first-fit contiguous claim and clear.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each item gives one
// result, shown on out_item for a single cycle with out_valid high; the
// receiver cannot stall, so capture it in that cycle. Toggle, clear, the
// unused action code and any claim with a length of zero or wider than a row
// are applied and answered from the S_OPER state.
// A claim sends a search token down a chain of row cells, one row per cycle
// from the last row to the first; it stops at the first row it reaches that
// has a fitting free run, else the result shows changed low once row 0 passes it on.
// The result strobe comes in the cycle busy drops, so a new item can be
// taken in that same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_seat_block_allocator (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire csba_pkg::in_t in_item,
  output logic               out_valid,
  output csba_pkg::out_t     out_item
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_OPER  = 3'b010,
    S_CLAIM = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  csba_pkg::in_t   cmd_r;
  csba_pkg::out_t  out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;
  logic            len_ok;
  logic            launch;
  csba_pkg::op_t   op;
  csba_pkg::tok_t  tok [csba_pkg::ROWS+1];
  csba_pkg::resp_t resp [csba_pkg::ROWS];
  csba_pkg::resp_t resp_all;
  logic [31:0]     row_ext;
  logic [31:0]     top_ext;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign len_ok = (in_item.run_length != 4'd0) &&
                  (32'(in_item.run_length) <= 32'(csba_pkg::COLS));
  assign launch = accept && (in_item.action == csba_pkg::ACT_CLAIM) && len_ok;

  // Inject the search token at the last row
  assign tok[csba_pkg::ROWS].valid = launch;
  assign tok[csba_pkg::ROWS].len   = in_item.run_length;

  // Broadcast the single-cycle operation
  assign op.toggle_go = (state_r == S_OPER) && (cmd_r.action == csba_pkg::ACT_TOGGLE);
  assign op.clear_go  = (state_r == S_OPER) && (cmd_r.action == csba_pkg::ACT_CLEAR);
  assign op.idx       = cmd_r.slot_index;

  // Row cell chain
  for (genvar r = 0; r < csba_pkg::ROWS; r++) begin : g_row
    csba_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .row_id  (csba_pkg::ROW_W'(r)),
      .op      (op),
      .tok_in  (tok[r+1]),
      .tok_out (tok[r]),
      .resp    (resp[r])
    );
  end

  // Merge responses: only one row acts at a time
  always_comb begin
    resp_all = '0;
    for (int r = 0; r < csba_pkg::ROWS; r++) begin
      resp_all = csba_pkg::resp_t'(resp_all | resp[r]);
    end
  end

  assign row_ext = 32'(resp_all.claim_row);
  assign top_ext = 32'(resp_all.claim_top);

  // Sequence the item and build the result
  always_comb begin
    state_nxt     = state_r;
    out_nxt       = '0;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = launch ? S_CLAIM : S_OPER;
        end
      end
      S_OPER: begin
        out_valid_nxt = 1'b1;
        if (cmd_r.action == csba_pkg::ACT_TOGGLE) begin
          out_nxt.changed     = resp_all.tg_changed;
          out_nxt.slot_status = resp_all.tg_status;
        end else if (cmd_r.action == csba_pkg::ACT_CLEAR) begin
          out_nxt.changed = resp_all.nonfree;
        end
        state_nxt = S_IDLE;
      end
      S_CLAIM: begin
        if (resp_all.claim_hit) begin
          out_valid_nxt         = 1'b1;
          out_nxt.changed       = 1'b1;
          out_nxt.block_row     = row_ext[2:0];
          out_nxt.block_top_col = top_ext[3:0];
          state_nxt             = S_IDLE;
        end else if (tok[0].valid) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the item and the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_item;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire
